// ===== design/ssfl_pkg.sv =====
// Shared constants and codes for the sorted symbol floor lookup block.
// Used by the top level, ssfl_step and ssfl_chk; has no dependencies.
package ssfl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int ENTRY_W     = ADDR_W + 1;    // {skip mark, start address}

    // Field widths on the stream ports
    localparam int OP_W     = 2;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OUT_IDX_W = 12;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 80;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILTERED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd4;

    // Symbol type characters that are kept ('t' and 'T')
    localparam logic [TYPE_W-1:0] TYPE_TEXT_LOWER = 8'h74;
    localparam logic [TYPE_W-1:0] TYPE_TEXT_UPPER = 8'h54;

    // One result transaction
    typedef struct packed {
        logic [ADDR_W-1:0]    entry_address;
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 found;
        logic [STATUS_W-1:0]  status;
    } result_t;

endpackage

// ===== design/sorted_symbol_floor_lookup.sv =====
// Top level of the sorted symbol floor lookup block: sequencer, table RAM and search unit.
// Depends on ssfl_pkg, ssfl_ram and ssfl_step.
//
// The block holds up to 4096 code-symbol start addresses in ascending order, each with a
// skip mark, in one RAM with a registered read port. One transaction is worked at a time
// and s_tready is low until it is finished. Every lookup, and every insert that is not
// filtered or full, runs an upper-bound binary search with the shared step unit, each
// probe a RAM read then a compare, so at most ceil(log2(n+1)) probes for n stored entries.
// Clear and unused codes go straight to EMIT. A lookup then reads the entry below the bound.
// An insert then moves the entries above the new position up one slot each through
// the single RAM port and writes the new entry; a filtered or full insert goes straight
// to EMIT. A result waits in the output register, and the next transaction is taken
// meanwhile. The table needs no clearing pass after reset.
module sorted_symbol_floor_lookup (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] address, [71:64] symbol_type, [72] skip_mark, [79:73] zero
    input  logic [ssfl_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [ssfl_pkg::OP_W-1:0]      s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [3] found, [15:4] entry_index, [79:16] entry_address
    output logic [ssfl_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        IDLE,
        SRCH,
        SRCH_CMP,
        LK_RD,
        LK_DATA,
        SHIFT_RD,
        SHIFT_WR,
        INS_WR,
        EMIT
    } state_t;

    state_t                        state_reg;
    logic [ssfl_pkg::OP_W-1:0]     op_reg;
    logic [ssfl_pkg::ADDR_W-1:0]   query_reg;
    logic                          mark_reg;
    logic [ssfl_pkg::CNT_W-1:0]    lo_reg;
    logic [ssfl_pkg::CNT_W-1:0]    hi_reg;
    logic [ssfl_pkg::IDX_W-1:0]    probe_reg;
    logic [ssfl_pkg::CNT_W-1:0]    ptr_reg;
    logic [ssfl_pkg::CNT_W-1:0]    count_reg;
    ssfl_pkg::result_t             res_reg;
    ssfl_pkg::result_t             out_reg;
    logic                          m_valid_reg;

    // Input field split
    logic [ssfl_pkg::ADDR_W-1:0]   in_address;
    logic [ssfl_pkg::TYPE_W-1:0]   in_type;
    logic                          in_mark;
    logic                          in_take;
    logic                          type_ok;
    logic                          table_full;
    logic [ssfl_pkg::STATUS_W-1:0] start_status;
    logic                          out_free;

    assign in_address = s_tdata[ssfl_pkg::ADDR_W-1:0];
    assign in_type    = s_tdata[ssfl_pkg::ADDR_W +: ssfl_pkg::TYPE_W];
    assign in_mark    = s_tdata[ssfl_pkg::ADDR_W + ssfl_pkg::TYPE_W];
    assign s_tready   = (state_reg == IDLE);
    assign in_take    = s_tvalid && s_tready;
    assign type_ok    = (in_type == ssfl_pkg::TYPE_TEXT_LOWER) ||
                        (in_type == ssfl_pkg::TYPE_TEXT_UPPER);
    assign table_full = (count_reg == ssfl_pkg::CNT_W'(ssfl_pkg::TABLE_DEPTH));
    assign out_free   = !m_valid_reg || m_tready;

    // Status known at accept time; the search paths fill it in later
    always_comb begin
        start_status = ssfl_pkg::ST_OK;
        if (s_tuser == ssfl_pkg::OP_INSERT) begin
            if (!type_ok) begin
                start_status = ssfl_pkg::ST_FILTERED;
            end else if (table_full) begin
                start_status = ssfl_pkg::ST_FULL;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // Table RAM and search unit
    logic                           ram_we;
    logic [ssfl_pkg::IDX_W-1:0]     ram_wr_addr;
    logic [ssfl_pkg::ENTRY_W-1:0]   ram_wr_data;
    logic [ssfl_pkg::IDX_W-1:0]     ram_rd_addr;
    logic [ssfl_pkg::ENTRY_W-1:0]   ram_rd_data;
    logic                           srch_active;
    logic [ssfl_pkg::IDX_W-1:0]     srch_mid;
    logic [ssfl_pkg::CNT_W-1:0]     srch_lo_next;
    logic [ssfl_pkg::CNT_W-1:0]     srch_hi_next;
    logic [ssfl_pkg::CNT_W-1:0]     lo_minus1;
    logic [ssfl_pkg::CNT_W-1:0]     ptr_minus1;

    assign lo_minus1  = lo_reg - ssfl_pkg::CNT_W'(1);
    assign ptr_minus1 = ptr_reg - ssfl_pkg::CNT_W'(1);

    ssfl_ram #(
        .WIDTH (ssfl_pkg::ENTRY_W),
        .DEPTH (ssfl_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ssfl_step u_step (
        .lo      (lo_reg),
        .hi      (hi_reg),
        .probe   (probe_reg),
        .entry   (ram_rd_data[ssfl_pkg::ADDR_W-1:0]),
        .query   (query_reg),
        .active  (srch_active),
        .mid     (srch_mid),
        .lo_next (srch_lo_next),
        .hi_next (srch_hi_next)
    );

    // RAM port control
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = ptr_reg[ssfl_pkg::IDX_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_addr = srch_mid;
        unique case (state_reg)
            LK_RD: begin
                ram_rd_addr = lo_minus1[ssfl_pkg::IDX_W-1:0];
            end
            SHIFT_RD: begin
                ram_rd_addr = ptr_minus1[ssfl_pkg::IDX_W-1:0];
            end
            SHIFT_WR: begin
                // move the entry read last cycle up one slot
                ram_we = 1'b1;
            end
            INS_WR: begin
                ram_we      = 1'b1;
                ram_wr_addr = lo_reg[ssfl_pkg::IDX_W-1:0];
                ram_wr_data = {mark_reg, query_reg};
            end
            default: begin
            end
        endcase
    end

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // result valid: set when a result is loaded, cleared when taken
            if (state_reg == EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (in_take) begin
                        op_reg    <= s_tuser;
                        query_reg <= in_address;
                        mark_reg  <= in_mark;
                        lo_reg    <= '0;
                        hi_reg    <= count_reg;
                        res_reg   <= ssfl_pkg::result_t'(ssfl_pkg::M_DATA_W'(start_status));
                        case (s_tuser)
                            ssfl_pkg::OP_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= EMIT;
                            end
                            ssfl_pkg::OP_INSERT: begin
                                if (!type_ok || table_full) begin
                                    state_reg <= EMIT;
                                end else begin
                                    state_reg <= SRCH;
                                end
                            end
                            ssfl_pkg::OP_LOOKUP: begin
                                state_reg <= SRCH;
                            end
                            default: begin
                                state_reg <= EMIT;
                            end
                        endcase
                    end
                end
                SRCH: begin
                    // issue a probe read, or finish with lo = upper bound
                    if (srch_active) begin
                        probe_reg <= srch_mid;
                        state_reg <= SRCH_CMP;
                    end else if (op_reg == ssfl_pkg::OP_INSERT) begin
                        ptr_reg   <= count_reg;
                        state_reg <= SHIFT_RD;
                    end else if (lo_reg == '0) begin
                        res_reg.status <= ssfl_pkg::ST_NOT_FOUND;
                        state_reg      <= EMIT;
                    end else begin
                        state_reg <= LK_RD;
                    end
                end
                SRCH_CMP: begin
                    lo_reg    <= srch_lo_next;
                    hi_reg    <= srch_hi_next;
                    state_reg <= SRCH;
                end
                LK_RD: begin
                    state_reg <= LK_DATA;
                end
                LK_DATA: begin
                    res_reg.entry_index   <= lo_minus1[ssfl_pkg::OUT_IDX_W-1:0];
                    res_reg.entry_address <= ram_rd_data[ssfl_pkg::ADDR_W-1:0];
                    if (ram_rd_data[ssfl_pkg::ADDR_W]) begin
                        res_reg.status <= ssfl_pkg::ST_SKIPPED;
                        res_reg.found  <= 1'b0;
                    end else begin
                        res_reg.status <= ssfl_pkg::ST_OK;
                        res_reg.found  <= 1'b1;
                    end
                    state_reg <= EMIT;
                end
                SHIFT_RD: begin
                    if (ptr_reg == lo_reg) begin
                        state_reg <= INS_WR;
                    end else begin
                        state_reg <= SHIFT_WR;
                    end
                end
                SHIFT_WR: begin
                    ptr_reg   <= ptr_minus1;
                    state_reg <= SHIFT_RD;
                end
                INS_WR: begin
                    count_reg             <= count_reg + ssfl_pkg::CNT_W'(1);
                    res_reg.entry_index   <= lo_reg[ssfl_pkg::OUT_IDX_W-1:0];
                    res_reg.entry_address <= query_reg;
                    state_reg             <= EMIT;
                end
                EMIT: begin
                    if (out_free) begin
                        out_reg   <= res_reg;
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/ssfl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/ssfl_step.sv =====
// Binary search step unit: next probe position and one 64-bit compare/bound update.
// Depends on ssfl_pkg.
module ssfl_step (
    input  logic [ssfl_pkg::CNT_W-1:0]  lo,
    input  logic [ssfl_pkg::CNT_W-1:0]  hi,
    input  logic [ssfl_pkg::IDX_W-1:0]  probe,      // position whose entry is in entry
    input  logic [ssfl_pkg::ADDR_W-1:0] entry,
    input  logic [ssfl_pkg::ADDR_W-1:0] query,
    output logic                        active,     // lo < hi, search not finished
    output logic [ssfl_pkg::IDX_W-1:0]  mid,
    output logic [ssfl_pkg::CNT_W-1:0]  lo_next,
    output logic [ssfl_pkg::CNT_W-1:0]  hi_next
);

    logic [ssfl_pkg::CNT_W-1:0] span;
    logic [ssfl_pkg::CNT_W-1:0] mid_full;
    logic                       le;

    // Midpoint; while active, mid < hi <= depth so it fits an index
    assign active   = lo < hi;
    assign span     = hi - lo;
    assign mid_full = lo + (span >> 1);
    assign mid      = mid_full[ssfl_pkg::IDX_W-1:0];

    // Upper-bound update: move past entries not above the query
    assign le      = entry <= query;
    assign lo_next = le ? ({1'b0, probe} + ssfl_pkg::CNT_W'(1)) : lo;
    assign hi_next = le ? hi : {1'b0, probe};

endmodule

// ===== design/ssfl_chk.sv =====
// Port-level checker for sorted_symbol_floor_lookup, attached by bind.
// Depends on ssfl_pkg.
module ssfl_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssfl_pkg::M_DATA_W-1:0] m_tdata
);

    logic [ssfl_pkg::STATUS_W-1:0] status;
    logic                          found;

    assign status = m_tdata[ssfl_pkg::STATUS_W-1:0];
    assign found  = m_tdata[ssfl_pkg::STATUS_W];

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Found only with ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found |-> status == ssfl_pkg::ST_OK)
        else $error("found with non-ok status");

    // Not found carries no entry
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ssfl_pkg::ST_NOT_FOUND |->
        m_tdata[ssfl_pkg::M_DATA_W-1:ssfl_pkg::STATUS_W] == '0)
        else $error("not found result carries entry fields");

    // Status is a defined code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status <= ssfl_pkg::ST_SKIPPED)
        else $error("undefined status code");

endmodule

bind sorted_symbol_floor_lookup ssfl_chk u_ssfl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
